// ===== rtl/core/cbtp_pkg.sv =====
package cbtp_pkg;

	// Field widths fixed by the pixel and register formats.
	localparam int unsigned COORD_W = 12;
	localparam int unsigned CFG_W   = 13;
	localparam int unsigned IDX_W   = 4;
	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned CFG_IDX_W = 2;

	// The quotient floor(84 * x / w) stays below 84 while x < w.
	localparam int unsigned QUOT_W  = 7;
	// 84 * 4095 needs 19 bits; one more keeps the shifted divisor compare safe.
	localparam int unsigned REM_W   = 20;
	localparam int unsigned NUM_DIV_CELLS = QUOT_W;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	// Register reset values.
	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd1024;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd768;

	// Colour table entries that the decoder names.
	localparam logic [IDX_W-1:0] IDX_WHITE      = 4'd0;
	localparam logic [IDX_W-1:0] IDX_RED        = 4'd6;
	localparam logic [IDX_W-1:0] IDX_PURPLE     = 4'd7;
	localparam logic [IDX_W-1:0] IDX_DARK_BLUE  = 4'd8;
	localparam logic [IDX_W-1:0] IDX_NEAR_BLACK = 4'd10;
	localparam logic [IDX_W-1:0] IDX_BLACK      = 4'd11;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
	} pix_req_t;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] alpha;
		logic [IDX_W-1:0]  colour_index;
		logic              out_of_frame;
	} pix_rsp_t;

	// Work carried along the divider chain.
	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [QUOT_W-1:0] quot;
		logic [CFG_W-1:0]  width;
		logic              top_band;
		logic              mid_band;
		logic              oof;
	} div_data_t;

	// Colour table, returned as {blue, green, red}.
	function automatic logic [3*CHAN_W-1:0] palette_bgr(input logic [IDX_W-1:0] idx);
		logic [3*CHAN_W-1:0] bgr;
		case (idx)
			4'd0:    bgr = 24'hff_ff_ff;
			4'd1:    bgr = 24'h00_ff_ff;
			4'd2:    bgr = 24'hff_ff_00;
			4'd3:    bgr = 24'h00_ff_00;
			4'd4:    bgr = 24'hff_00_ff;
			4'd5:    bgr = 24'h00_00_ff;
			4'd6:    bgr = 24'hff_00_00;
			4'd7:    bgr = 24'hba_01_5f;
			4'd8:    bgr = 24'h8d_3d_00;
			4'd9:    bgr = 24'h22_22_22;
			4'd10:   bgr = 24'h10_10_10;
			default: bgr = 24'h00_00_00;
		endcase
		return bgr;
	endfunction

endpackage

// ===== rtl/core/cbtp_front.sv =====
module cbtp_front #(
	parameter int unsigned MAX_WIDTH  = 4096,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_valid,
	input  cbtp_pkg::pix_req_t       in_req,
	input  logic [cbtp_pkg::CFG_W-1:0] frame_width,
	input  logic [cbtp_pkg::CFG_W-1:0] frame_height,
	output logic                     out_valid,
	output cbtp_pkg::div_data_t      out_data
);
	import cbtp_pkg::*;

	// Largest usable size: the register range caps the parameter.
	localparam int unsigned CFG_MAX = (1 << CFG_W) - 1;
	localparam int unsigned W_CAP = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
	localparam int unsigned H_CAP = (MAX_HEIGHT < CFG_MAX) ? MAX_HEIGHT : CFG_MAX;
	localparam logic [CFG_W-1:0] W_CAP_V = W_CAP[CFG_W-1:0];
	localparam logic [CFG_W-1:0] H_CAP_V = H_CAP[CFG_W-1:0];

	logic [CFG_W-1:0] width_c;
	logic [CFG_W-1:0] height_c;
	logic [CFG_W+1:0] y3;
	logic [CFG_W+1:0] y4;
	logic [CFG_W+1:0] h2;
	logic [CFG_W+1:0] h3;
	logic [REM_W-1:0] x_ext;
	div_data_t        data_d;

	// Clamp the frame size, classify the line into its band, flag out-of-frame pixels and form the dividend 84x.
	always_comb begin
		width_c  = (frame_width > W_CAP_V) ? W_CAP_V : frame_width;
		height_c = (frame_height > H_CAP_V) ? H_CAP_V : frame_height;
		y3 = ((CFG_W+2)'(in_req.pixel_y) << 1) + (CFG_W+2)'(in_req.pixel_y);
		y4 = (CFG_W+2)'(in_req.pixel_y) << 2;
		h2 = (CFG_W+2)'(height_c) << 1;
		h3 = ((CFG_W+2)'(height_c) << 1) + (CFG_W+2)'(height_c);
		x_ext = REM_W'(in_req.pixel_x);

		data_d.rem      = (x_ext << 6) + (x_ext << 4) + (x_ext << 2);
		data_d.quot     = '0;
		data_d.width    = width_c;
		data_d.top_band = (y3 < h2);
		data_d.mid_band = (y4 < h3);
		data_d.oof      = (width_c == '0) || (height_c == '0)
		                  || ({1'b0, in_req.pixel_x} >= width_c)
		                  || ({1'b0, in_req.pixel_y} >= height_c);
	end

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= data_d;
		end
	end

endmodule

// ===== rtl/core/cbtp_div_cell.sv =====
module cbtp_div_cell #(
	parameter int unsigned SHIFT = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  cbtp_pkg::div_data_t in_data,
	output logic                out_valid,
	output cbtp_pkg::div_data_t out_data
);
	import cbtp_pkg::*;

	logic [REM_W-1:0] divisor;
	logic             take;
	div_data_t        data_d;

	// One restoring step: subtract the shifted width when it fits.
	always_comb begin
		divisor = REM_W'(in_data.width) << SHIFT;
		take    = (in_data.rem >= divisor);
		data_d  = in_data;
		data_d.rem  = take ? (in_data.rem - divisor) : in_data.rem;
		data_d.quot = {in_data.quot[QUOT_W-2:0], take};
	end

	// Cell valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	// Cell payload handed to the neighbor.
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= data_d;
		end
	end

endmodule

// ===== rtl/core/cbtp_decode.sv =====
module cbtp_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  cbtp_pkg::div_data_t in_data,
	output logic                out_valid,
	output cbtp_pkg::pix_rsp_t  out_rsp
);
	import cbtp_pkg::*;

	logic [QUOT_W-1:0]   q;
	logic [2:0]          seg;
	logic [4:0]          ramp;
	logic [IDX_W-1:0]    idx;
	logic [3*CHAN_W-1:0] bgr;
	pix_rsp_t            rsp_d;

	// The quotient q is floor(84x/w): a bar of sevenths spans 12, a 28th spans 3.
	always_comb begin
		q = in_data.quot;
		if (q >= 7'd72) begin
			seg = 3'd6;
		end else if (q >= 7'd60) begin
			seg = 3'd5;
		end else if (q >= 7'd48) begin
			seg = 3'd4;
		end else if (q >= 7'd36) begin
			seg = 3'd3;
		end else if (q >= 7'd24) begin
			seg = 3'd2;
		end else if (q >= 7'd12) begin
			seg = 3'd1;
		end else begin
			seg = 3'd0;
		end
		// Grey ramp steps on 21sths of the width.
		ramp = 5'd26 - q[QUOT_W-1:2];

		if (in_data.oof) begin
			idx = IDX_BLACK;
		end else if (in_data.top_band) begin
			idx = IDX_W'(seg);
		end else if (in_data.mid_band) begin
			idx = seg[0] ? IDX_NEAR_BLACK : (IDX_RED - IDX_W'(seg));
		end else if (q < 7'd15) begin
			idx = IDX_DARK_BLUE;
		end else if (q < 7'd30) begin
			idx = IDX_WHITE;
		end else if (q < 7'd45) begin
			idx = IDX_PURPLE;
		end else if (q < 7'd60) begin
			idx = IDX_NEAR_BLACK;
		end else if (q < 7'd72) begin
			idx = ramp[IDX_W-1:0];
		end else begin
			idx = IDX_NEAR_BLACK;
		end

		bgr = palette_bgr(idx);
		rsp_d.blue         = bgr[3*CHAN_W-1:2*CHAN_W];
		rsp_d.green        = bgr[2*CHAN_W-1:CHAN_W];
		rsp_d.red          = bgr[CHAN_W-1:0];
		rsp_d.alpha        = 8'hff;
		rsp_d.colour_index = idx;
		rsp_d.out_of_frame = in_data.oof;
	end

	// Output register valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			out_rsp <= rsp_d;
		end
	end

endmodule

// ===== rtl/core/color_bar_test_pattern.sv =====
// Pipeline: one front stage, seven divider cells that each settle one quotient bit
// and one output register lie between an accepted request and its result.
// Throughput: one pixel per clock; the whole chain holds while the output stalls.
// Reset: arst_n clears all valid bits at once and sets the frame size to
// 1024 x 768; no clearing pass is needed.
module color_bar_test_pattern #(
	parameter int unsigned MAX_WIDTH  = 4096,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  cbtp_pkg::pix_req_t             in_req,
	output logic                           out_valid,
	input  logic                           out_stall,
	output cbtp_pkg::pix_rsp_t             out_rsp,
	input  logic                           cfg_we,
	input  logic [cbtp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cbtp_pkg::CFG_W-1:0]     cfg_data
);
	import cbtp_pkg::*;

	logic [CFG_W-1:0]           frame_width_q;
	logic [CFG_W-1:0]           frame_height_q;
	logic                       adv;
	logic [NUM_DIV_CELLS:0]     stage_vld;
	div_data_t                  stage_data [NUM_DIV_CELLS+1];

	// The chain moves whenever the output register is free or being drained.
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front stage: clamp, band and out-of-frame flags, and the dividend 84x.
	cbtp_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_valid     (in_valid),
		.in_req       (in_req),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.out_valid    (stage_vld[0]),
		.out_data     (stage_data[0])
	);

	// Divider chain, most significant quotient bit first.
	for (genvar g = 0; g < NUM_DIV_CELLS; g++) begin : g_cell
		cbtp_div_cell #(
			.SHIFT (NUM_DIV_CELLS - 1 - g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (stage_vld[g]),
			.in_data   (stage_data[g]),
			.out_valid (stage_vld[g+1]),
			.out_data  (stage_data[g+1])
		);
	end

	// Colour selection and output register.
	cbtp_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (stage_vld[NUM_DIV_CELLS]),
		.in_data   (stage_data[NUM_DIV_CELLS]),
		.out_valid (out_valid),
		.out_rsp   (out_rsp)
	);

	// An accepted request always enters the front stage.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> stage_vld[0])
		else $error("accepted request did not enter the chain");

	// A pixel outside the frame is always black.
	a_oof_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_rsp.out_of_frame |-> out_rsp.colour_index == IDX_BLACK)
		else $error("out-of-frame pixel is not black");

	// Every result is opaque and uses a real table entry.
	a_rsp_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_rsp.alpha == 8'hff && out_rsp.colour_index <= IDX_BLACK)
		else $error("illegal result value");

	// A stalled result keeps the chain frozen.
	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(stage_vld))
		else $error("chain moved while output stalled");

endmodule
